>>> src/whirlpool_hash_defines.svh
// Assertion helpers used by the whirlpool hash sequencer (whirl_ctrl).
`ifndef WHIRLPOOL_HASH_DEFINES_SVH
`define WHIRLPOOL_HASH_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define WH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/whirl_pkg.sv
// ----------------------------------------------------------------------------
// whirl_pkg
// Types, constants and round function of the Whirlpool-512 hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package whirl_pkg;

  localparam int unsigned RoundsDefault = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h18,8'h23,8'hC6,8'hE8,8'h87,8'hB8,8'h01,8'h4F,8'h36,8'hA6,8'hD2,8'hF5,8'h79,8'h6F,8'h91,8'h52,
    8'h60,8'hBC,8'h9B,8'h8E,8'hA3,8'h0C,8'h7B,8'h35,8'h1D,8'hE0,8'hD7,8'hC2,8'h2E,8'h4B,8'hFE,8'h57,
    8'h15,8'h77,8'h37,8'hE5,8'h9F,8'hF0,8'h4A,8'hDA,8'h58,8'hC9,8'h29,8'h0A,8'hB1,8'hA0,8'h6B,8'h85,
    8'hBD,8'h5D,8'h10,8'hF4,8'hCB,8'h3E,8'h05,8'h67,8'hE4,8'h27,8'h41,8'h8B,8'hA7,8'h7D,8'h95,8'hD8,
    8'hFB,8'hEE,8'h7C,8'h66,8'hDD,8'h17,8'h47,8'h9E,8'hCA,8'h2D,8'hBF,8'h07,8'hAD,8'h5A,8'h83,8'h33,
    8'h63,8'h02,8'hAA,8'h71,8'hC8,8'h19,8'h49,8'hD9,8'hF2,8'hE3,8'h5B,8'h88,8'h9A,8'h26,8'h32,8'hB0,
    8'hE9,8'h0F,8'hD5,8'h80,8'hBE,8'hCD,8'h34,8'h48,8'hFF,8'h7A,8'h90,8'h5F,8'h20,8'h68,8'h1A,8'hAE,
    8'hB4,8'h54,8'h93,8'h22,8'h64,8'hF1,8'h73,8'h12,8'h40,8'h08,8'hC3,8'hEC,8'hDB,8'hA1,8'h8D,8'h3D,
    8'h97,8'h00,8'hCF,8'h2B,8'h76,8'h82,8'hD6,8'h1B,8'hB5,8'hAF,8'h6A,8'h50,8'h45,8'hF3,8'h30,8'hEF,
    8'h3F,8'h55,8'hA2,8'hEA,8'h65,8'hBA,8'h2F,8'hC0,8'hDE,8'h1C,8'hFD,8'h4D,8'h92,8'h75,8'h06,8'h8A,
    8'hB2,8'hE6,8'h0E,8'h1F,8'h62,8'hD4,8'hA8,8'h96,8'hF9,8'hC5,8'h25,8'h59,8'h84,8'h72,8'h39,8'h4C,
    8'h5E,8'h78,8'h38,8'h8C,8'hD1,8'hA5,8'hE2,8'h61,8'hB3,8'h21,8'h9C,8'h1E,8'h43,8'hC7,8'hFC,8'h04,
    8'h51,8'h99,8'h6D,8'h0D,8'hFA,8'hDF,8'h7E,8'h24,8'h3B,8'hAB,8'hCE,8'h11,8'h8F,8'h4E,8'hB7,8'hEB,
    8'h3C,8'h81,8'h94,8'hF7,8'hB9,8'h13,8'h2C,8'hD3,8'hE7,8'h6E,8'hC4,8'h03,8'h56,8'h44,8'h7F,8'hA9,
    8'h2A,8'hBB,8'hC1,8'h53,8'hDC,8'h0B,8'h9D,8'h6C,8'h31,8'h74,8'hF6,8'h46,8'hAC,8'h89,8'h14,8'hE1,
    8'h16,8'h3A,8'h69,8'h09,8'h70,8'hB6,8'hD0,8'hED,8'hCC,8'h42,8'h98,8'hA4,8'h28,8'h5C,8'hF8,8'h86
  };

  localparam logic [3:0] MIX_ROW [8] = '{4'h1, 4'h1, 4'h4, 4'h1, 4'h8, 4'h5, 4'h2, 4'h9};
  localparam logic [7:0] MIX_POLY = 8'h1D;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_FIX, ST_CSTART, ST_KEY, ST_STATE, ST_CEND, ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {AFT_IDLE, AFT_FIX, AFT_OUT} after_e;

  typedef struct packed {
    logic       load;
    logic       fix;
    logic       cstart;
    logic       key_rnd;
    logic       st_rnd;
    logic       cend;
    logic       clear;
    logic [2:0] oidx;
  } dp_cmd_t;

  typedef struct packed {
    logic pos7;
    logic full;
    logic extra;
  } dp_stat_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? MIX_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    gf_mul = (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^
             (m[2] ? a4 : 8'h00) ^ (m[3] ? a8 : 8'h00);
  endfunction

  // Byte (r,c) sits at bits 511-8*(8r+c) downward.
  function automatic logic [511:0] w_round(input logic [511:0] st, input logic [511:0] k);
    logic [7:0] t [64];
    logic [7:0] acc;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        t[r*8+c] = SBOX[st[511 - 8*((((r + 8 - c) % 8) * 8) + c) -: 8]];
      end
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        acc = 8'h00;
        for (int j = 0; j < 8; j++) begin
          acc = acc ^ gf_mul(t[r*8+j], MIX_ROW[(c + 8 - j) % 8]);
        end
        w_round[511 - 8*(r*8+c) -: 8] = acc ^ k[511 - 8*(r*8+c) -: 8];
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> src/whirl_if.sv
// ----------------------------------------------------------------------------
// whirl_in_if / whirl_out_if
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface whirl_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [6:0]  valid_bits;
  logic        last_word;
  modport source (output valid, msg_word, valid_bits, last_word, input ready);
  modport sink   (input valid, msg_word, valid_bits, last_word, output ready);
endinterface

interface whirl_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

`default_nettype wire

>>> src/whirl_dp.sv
// ----------------------------------------------------------------------------
// whirl_dp
// Block buffer, padding, chaining value and one shared W round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module whirl_dp #(
  parameter int unsigned ROUNDS = whirl_pkg::RoundsDefault,
  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  whirl_pkg::dp_cmd_t   cmd_i,
  input  wire [RW-1:0]         rnd_i,
  input  wire [63:0]           msg_word_i,
  input  wire [6:0]            valid_bits_i,
  input  wire                  last_word_i,
  output whirl_pkg::dp_stat_t  stat_o,
  output logic [63:0]          digest_word_o
);

  logic [63:0]  buf_q [8];
  logic [511:0] chain_q, st_q, key_q;
  logic [2:0]   pos_q;
  logic [63:0]  len_q;
  logic         full_q, extra_q;

  logic [6:0]   vb;
  logic [63:0]  masked;
  logic [9:0]   used;
  logic         full_w, extra_w;
  logic [511:0] buf_flat, rc, rnd_in, rnd_key, rnd_out;
  logic [7:0]   rbase;
  logic [63:0]  ld_w [8];

  assign vb     = (last_word_i && valid_bits_i <= 7'd64) ? valid_bits_i : 7'd64;
  assign masked = msg_word_i & ~({64{1'b1}} >> vb);
  assign used   = {1'b0, pos_q, 6'd0} + {3'd0, vb};
  assign full_w  = (used == 10'd512);
  assign extra_w = !full_w && (used >= 10'd256);

  assign buf_flat = {buf_q[0], buf_q[1], buf_q[2], buf_q[3],
                     buf_q[4], buf_q[5], buf_q[6], buf_q[7]};

  // Last-word slot contents: masked word at pos, pad bit at used, zeros above.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ld_w[i] = (3'(i) == pos_q) ? masked : 64'd0;
      if (!full_w && 3'(i) == used[8:6]) begin
        ld_w[i] = ld_w[i] | (64'h8000_0000_0000_0000 >> used[5:0]);
      end
    end
  end

  // Round constant: one S-box row in row 0, zeros elsewhere.
  assign rbase = 8'(rnd_i) << 3;
  always_comb begin
    rc = '0;
    for (int i = 0; i < 8; i++) begin
      rc[511 - 8*i -: 8] = whirl_pkg::SBOX[rbase + 8'(i)];
    end
  end

  // Shared round unit: key round, then state round under the new key.
  assign rnd_in  = cmd_i.key_rnd ? key_q : st_q;
  assign rnd_key = cmd_i.key_rnd ? rc : key_q;
  assign rnd_out = whirl_pkg::w_round(rnd_in, rnd_key);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (!last_word_i) begin
        buf_q[pos_q] <= msg_word_i;
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (3'(i) >= pos_q) begin
            buf_q[i] <= ld_w[i];
          end
        end
      end
    end else if (cmd_i.fix) begin
      if (full_q || extra_q) begin
        for (int i = 0; i < 7; i++) begin
          buf_q[i] <= (i == 0 && full_q) ? 64'h8000_0000_0000_0000 : 64'd0;
        end
      end
      buf_q[7] <= len_q;
    end
    if (cmd_i.cstart) begin
      key_q <= chain_q;
      st_q  <= buf_flat ^ chain_q;
    end else if (cmd_i.key_rnd) begin
      key_q <= rnd_out;
    end else if (cmd_i.st_rnd) begin
      st_q <= rnd_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      full_q  <= 1'b0;
      extra_q <= 1'b0;
    end else if (cmd_i.clear) begin
      chain_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        pos_q   <= pos_q + 3'd1;
        len_q   <= len_q + 64'(vb);
        full_q  <= last_word_i && full_w;
        extra_q <= last_word_i && extra_w;
      end
      if (cmd_i.cend) begin
        chain_q <= chain_q ^ st_q ^ buf_flat;
      end
    end
  end

  assign stat_o.pos7  = (pos_q == 3'd7);
  assign stat_o.full  = full_q;
  assign stat_o.extra = extra_q;
  assign digest_word_o = chain_q[511 - 64*cmd_i.oidx -: 64];

endmodule

`default_nettype wire

>>> src/whirl_ctrl.sv
// ----------------------------------------------------------------------------
// whirl_ctrl
// Sequencer: absorb, padding steps, round schedule and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "whirlpool_hash_defines.svh"

module whirl_ctrl #(
  parameter int unsigned ROUNDS = whirl_pkg::RoundsDefault,
  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  whirl_pkg::dp_stat_t  stat_i,
  output whirl_pkg::dp_cmd_t   cmd_o,
  output logic [RW-1:0]        rnd_o
);

  localparam logic [RW-1:0] RndLast = RW'(ROUNDS - 1);

  whirl_pkg::ctrl_state_e state_q, state_d;
  whirl_pkg::after_e      aft_q, aft_d;
  logic [RW-1:0]          rnd_q, rnd_d;
  logic [2:0]             oidx_q, oidx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= whirl_pkg::ST_IDLE;
      aft_q   <= whirl_pkg::AFT_IDLE;
      rnd_q   <= '0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      aft_q   <= aft_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    aft_d       = aft_q;
    rnd_d       = rnd_q;
    oidx_d      = oidx_q;
    cmd_o       = '0;
    cmd_o.oidx  = oidx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      whirl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = whirl_pkg::ST_PAD;
          end else if (stat_i.pos7) begin
            aft_d   = whirl_pkg::AFT_IDLE;
            state_d = whirl_pkg::ST_CSTART;
          end
        end
      end
      whirl_pkg::ST_PAD: begin
        if (stat_i.full || stat_i.extra) begin
          aft_d   = whirl_pkg::AFT_FIX;
          state_d = whirl_pkg::ST_CSTART;
        end else begin
          state_d = whirl_pkg::ST_FIX;
        end
      end
      whirl_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        aft_d     = whirl_pkg::AFT_OUT;
        state_d   = whirl_pkg::ST_CSTART;
      end
      whirl_pkg::ST_CSTART: begin
        cmd_o.cstart = 1'b1;
        rnd_d        = '0;
        state_d      = whirl_pkg::ST_KEY;
      end
      whirl_pkg::ST_KEY: begin
        cmd_o.key_rnd = 1'b1;
        state_d       = whirl_pkg::ST_STATE;
      end
      whirl_pkg::ST_STATE: begin
        cmd_o.st_rnd = 1'b1;
        if (rnd_q == RndLast) begin
          state_d = whirl_pkg::ST_CEND;
        end else begin
          rnd_d   = rnd_q + RW'(1);
          state_d = whirl_pkg::ST_KEY;
        end
      end
      whirl_pkg::ST_CEND: begin
        cmd_o.cend = 1'b1;
        unique case (aft_q)
          whirl_pkg::AFT_FIX: state_d = whirl_pkg::ST_FIX;
          whirl_pkg::AFT_OUT: begin
            oidx_d  = '0;
            state_d = whirl_pkg::ST_OUT;
          end
          default: state_d = whirl_pkg::ST_IDLE;
        endcase
      end
      whirl_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (oidx_q == 3'd7) begin
            cmd_o.clear = 1'b1;
            state_d     = whirl_pkg::ST_IDLE;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: state_d = whirl_pkg::ST_IDLE;
    endcase
  end

  assign rnd_o = rnd_q;

  `WH_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input taken while digest pending")
  `WH_ASSERT(a_done_idle, (out_valid_o && out_ready_i && oidx_q == 3'd7) |=> in_ready_o, "no return to idle after digest")
  `WH_ASSERT(a_key_then_state, (state_q == whirl_pkg::ST_KEY) |=> (state_q == whirl_pkg::ST_STATE), "key round not followed by state round")
  `WH_ASSERT_ALWAYS(a_rnd_range, rnd_q <= RndLast, "round counter out of range")

endmodule

`default_nettype wire

>>> src/whirlpool_hash.sv
// Whirlpool-512 hash. Message words enter as big-endian 64-bit items; a word that
// is not last is taken in the idle state, and each eighth word starts a compression
// (CSTART, key and state rounds, CEND) in one shared round unit that runs the key
// round and then the state round of each round in turn. A last word adds the PAD
// and FIX padding steps and one or two compressions, then eight digest items leave
// at one per cycle while the output side is ready; after the eighth the state is
// cleared for the next message. Input is taken only while no work is pending.
// ----------------------------------------------------------------------------
// whirlpool_hash
// Top level: sequencer and datapath of the Whirlpool-512 hash.
// ----------------------------------------------------------------------------
`default_nettype none

module whirlpool_hash #(
  parameter int unsigned ROUNDS = whirl_pkg::RoundsDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  whirl_in_if.sink     msg_i,
  whirl_out_if.source  dig_o
);

  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  whirl_pkg::dp_cmd_t  cmd;
  whirl_pkg::dp_stat_t stat;
  logic [RW-1:0]       rnd;

  whirl_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (msg_i.valid),
    .in_last_i   (msg_i.last_word),
    .in_ready_o  (msg_i.ready),
    .out_valid_o (dig_o.valid),
    .out_ready_i (dig_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rnd_o       (rnd)
  );

  whirl_dp #(.ROUNDS(ROUNDS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rnd_i         (rnd),
    .msg_word_i    (msg_i.msg_word),
    .valid_bits_i  (msg_i.valid_bits),
    .last_word_i   (msg_i.last_word),
    .stat_o        (stat),
    .digest_word_o (dig_o.digest_word)
  );

  assign dig_o.digest_last = (cmd.oidx == 3'd7);

endmodule

`default_nettype wire

>>> sim/tb_whirl_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_whirl_if
// Note: the message and digest channels come from src/whirl_if.sv; this file
// only holds the testbench's shared types.
// ----------------------------------------------------------------------------
package tb_whirl_pkg;
  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_item_t;
endpackage

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Whirlpool-512 hash testbench: random message streams with partial and empty
// last words, padding edge cases and random idling on both channels; digests
// are checked against an in-bench model of the hash.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned msgs_sent = 0;

  whirl_in_if  msg_ch ();
  whirl_out_if dig_ch ();

  whirlpool_hash #(.ROUNDS(NUM_ROUNDS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .msg_i (msg_ch),
    .dig_o (dig_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hash model: chaining value, block buffer, position and length.
  class digest_board;
    logic [63:0] chain [8];
    logic [63:0] blk [8];
    int unsigned pos;
    logic [63:0] bit_len;
    tb_whirl_pkg::digest_item_t pending [$];
    int unsigned errors;
    int unsigned digests;

    function new();
      errors = 0;
      digests = 0;
      clear_state();
    endfunction

    function void clear_state();
      for (int i = 0; i < 8; i++) begin
        chain[i] = '0;
        blk[i] = '0;
      end
      pos = 0;
      bit_len = '0;
    endfunction

    function logic [7:0] sbox(input logic [7:0] x);
      sbox = whirl_pkg::SBOX[x];
    endfunction

    function logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
      logic [8:0] x;
      logic [7:0] r;
      x = {1'b0, a};
      r = '0;
      for (int b = 0; b < 4; b++) begin
        if (m[b]) r ^= x[7:0];
        x = {x[7:0], 1'b0};
        if (x[8]) x ^= 9'h11D;
      end
      gmul = r;
    endfunction

    function void w_rnd(ref logic [7:0] st [64], input logic [7:0] k [64]);
      logic [7:0] t [64];
      logic [7:0] acc;
      logic [3:0] row [8];
      row = '{4'h1, 4'h1, 4'h4, 4'h1, 4'h8, 4'h5, 4'h2, 4'h9};
      for (int r = 0; r < 8; r++)
        for (int c = 0; c < 8; c++)
          t[r*8+c] = sbox(st[((r + 8 - c) % 8) * 8 + c]);
      for (int r = 0; r < 8; r++)
        for (int c = 0; c < 8; c++) begin
          acc = '0;
          for (int j = 0; j < 8; j++) acc ^= gmul(t[r*8+j], row[(c + 8 - j) % 8]);
          st[r*8+c] = acc ^ k[r*8+c];
        end
    endfunction

    function void compress();
      logic [7:0] k [64];
      logic [7:0] st [64];
      logic [7:0] rc [64];
      logic [63:0] w;
      for (int i = 0; i < 64; i++) begin
        k[i] = chain[i/8][63 - 8*(i%8) -: 8];
        st[i] = blk[i/8][63 - 8*(i%8) -: 8] ^ k[i];
        rc[i] = '0;
      end
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        for (int i = 0; i < 8; i++) rc[i] = sbox(8'(r*8 + i));
        w_rnd(k, rc);
        w_rnd(st, k);
      end
      for (int i = 0; i < 8; i++) begin
        w = '0;
        for (int j = 0; j < 8; j++) w = {w[55:0], st[i*8+j]};
        chain[i] ^= w ^ blk[i];
      end
    endfunction

    function void note_word(input logic [63:0] word, input logic [6:0] vb, input logic last);
      int unsigned v, used;
      logic [63:0] total;
      if (!last) begin
        blk[pos] = word;
        bit_len += 64;
        if (pos == 7) compress();
        pos = (pos + 1) % 8;
        return;
      end
      v = (vb > 64) ? 64 : vb;
      if (v == 0) word = '0;
      else if (v < 64) word &= ~64'd0 << (64 - v);
      total = bit_len + 64'(v);
      blk[pos] = word;
      for (int i = pos + 1; i < 8; i++) blk[i] = '0;
      used = pos * 64 + v;
      if (used == 512) begin
        compress();
        for (int i = 0; i < 8; i++) blk[i] = '0;
        used = 0;
      end
      blk[used / 64][63 - (used % 64)] = 1'b1;
      if (used >= 256) begin
        compress();
        for (int i = 0; i < 8; i++) blk[i] = '0;
      end
      blk[7] = total;
      compress();
      for (int i = 0; i < 8; i++) pending.push_back('{chain[i], i == 7});
      clear_state();
    endfunction

    function void check_digest(input logic [63:0] word, input logic last);
      tb_whirl_pkg::digest_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word %h last %0b", $time, word, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (word !== e.word) begin
        $display("%0t: digest_word expected %h actual %h", $time, e.word, word);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: digest_last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
      if (last) digests++;
    endfunction
  endclass

  digest_board board = new();

  function int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin
    msg_ch.valid = 1'b0;
    msg_ch.msg_word = '0;
    msg_ch.valid_bits = '0;
    msg_ch.last_word = 1'b0;
    dig_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output side: random stalls, with quiet stretches.
  int unsigned stall_left = 0;
  bit calm = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (dig_ch.valid && dig_ch.ready) board.check_digest(dig_ch.digest_word, dig_ch.digest_last);
      if ($urandom_range(0, 199) == 0) calm = ~calm;
      if (stall_left > 0) begin
        stall_left--;
        dig_ch.ready <= 1'b0;
      end else begin
        dig_ch.ready <= 1'b1;
        if (!calm) stall_left = gap_len();
      end
    end
  end

  task automatic send_word(input logic [63:0] w, input logic [6:0] vb, input logic last);
    int unsigned g;
    g = calm ? 0 : gap_len();
    if (g > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.msg_word <= w;
    msg_ch.valid_bits <= vb;
    msg_ch.last_word <= last;
    do @(posedge clk_i); while (!msg_ch.ready);
    board.note_word(w, vb, last);
    words_sent++;
    if (last) msgs_sent++;
  endtask

  function logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // Message of n full words and a last word with vb valid bits.
  task automatic send_msg(input int unsigned n, input logic [6:0] vb);
    for (int i = 0; i < n; i++) send_word(rnd64(), 7'($urandom()), 1'b0);
    send_word(rnd64(), vb, 1'b1);
  endtask

  initial begin
    logic [6:0] vb;
    int unsigned n;
    // falling edge at time zero fires the asynchronous reset
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty message, all-ones and all-zero words, over-range valid bits
    send_word('0, 7'd0, 1'b1);
    send_word('1, 7'd127, 1'b1);
    send_word('1, 7'd64, 1'b1);
    send_word('1, 7'd1, 1'b1);
    send_word('0, 7'd63, 1'b1);
    send_msg(3, 7'd63);   // padding just below the extra-block threshold
    send_msg(4, 7'd0);    // pad at bit 256: extra block
    send_msg(7, 7'd64);   // full final block
    send_msg(8, 7'd17);   // second block
    while (words_sent < 420) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 9);
      case ($urandom_range(0, 5))
        0: vb = 7'd64;
        1: vb = 7'd0;
        2: vb = 7'($urandom_range(65, 127));
        default: vb = 7'($urandom_range(1, 63));
      endcase
      send_msg(n, vb);
    end
    msg_ch.valid <= 1'b0;
    while (board.pending.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("tb: %0d message words in %0d messages, %0d digests checked",
             words_sent, msgs_sent, board.digests);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
